### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks clocked on clk and gated by arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication: when trigger holds, consequence holds in the next cycle
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// types and constants of the descriptor slot allocator
// ----------------------------------------------------------------------------
package dsa_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int STRIDE_W  = 16;
	localparam int PROD_W    = SLOT_W + STRIDE_W;
	localparam int CAP_W     = 11;
	localparam int ADDR_W    = 64;
	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;

	// request codes
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_INIT  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_EXHAUSTED    = 3'd1;
	localparam logic [2:0] ST_OUT_OF_RANGE = 3'd2;
	localparam logic [2:0] ST_DOUBLE_FREE  = 3'd3;
	localparam logic [2:0] ST_IGNORED      = 3'd4;

	// register indexes (byte address 8*i)
	localparam logic [2:0] REG_CAPACITY = 3'd0;
	localparam logic [2:0] REG_STRIDE   = 3'd1;
	localparam logic [2:0] REG_CPU_BASE = 3'd2;
	localparam logic [2:0] REG_GPU_BASE = 3'd3;
	localparam logic [2:0] REG_GPU_VIS  = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        handle_present;
		logic [15:0] free_index;
	} dsa_req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              granted;
		logic [9:0]        slot_index;
		logic [ADDR_W-1:0] cpu_address;
		logic [ADDR_W-1:0] gpu_address;
	} dsa_rsp_t;

endpackage

### rtl/descriptor_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_unit
// lifo free-list slot allocator with per-slot busy bits and address output
// ----------------------------------------------------------------------------
// sequence: allocate and an in-range free read the stack or busy memory in
//   S_ALLOC_RD or S_FREE_RD before S_RESP; exhausted allocate, ignored or
//   out-of-range free and unknown codes go straight to S_RESP; initialize
//   sweeps S_INIT over the pool first. one request in flight: req_stall holds
//   new requests until the result register has taken the pending result
// reset: control and config clear at once, memories are not swept
module descriptor_slot_allocator_unit
	import dsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  dsa_req_t           req,
	// result channel
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output dsa_rsp_t           rsp,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_FREE_RD,
		S_INIT,
		S_RESP
	} state_t;

	// configuration registers
	logic [CAP_W-1:0]    cfg_cap_q;
	logic [STRIDE_W-1:0] cfg_stride_q;
	logic [ADDR_W-1:0]   cfg_cpu_base_q;
	logic [ADDR_W-1:0]   cfg_gpu_base_q;
	logic                cfg_gpu_vis_q;
	logic                cfg_wr;
	logic [2:0]          cfg_idx;

	// control state
	state_t              state_q;
	logic [CNT_W-1:0]    fc_q;       // stacked entries
	logic [CNT_W-1:0]    pool_q;     // capacity latched by initialize
	logic [SLOT_W-1:0]   fill_q;     // initialize sweep position
	logic [SLOT_W-1:0]   idx_q;      // slot being freed

	// pending result
	logic [2:0]          res_status_q;
	logic                res_grant_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PROD_W-1:0]   prod_q;

	// output register
	logic                rsp_valid_q;
	dsa_rsp_t            rsp_q;

	// memories
	logic [SLOT_W-1:0]   stack_mem [MAX_SLOTS];
	logic                busy_mem  [MAX_SLOTS];
	logic                stack_we;
	logic [SLOT_W-1:0]   stack_wa;
	logic [SLOT_W-1:0]   stack_wd;
	logic [SLOT_W-1:0]   stack_ra;
	logic [SLOT_W-1:0]   stack_rdata;
	logic                busy_we;
	logic [SLOT_W-1:0]   busy_wa;
	logic                busy_wd;
	logic [SLOT_W-1:0]   busy_ra;
	logic                busy_rdata;

	logic                req_xfer;
	logic                rsp_free;
	logic [CNT_W-1:0]    cap_sat;
	logic [SLOT_W-1:0]   cap_m1;
	logic [ADDR_W-1:0]   prod_ext;

	// ------------------------------------------------------------------
	// register port: writes land on the access phase, reads are direct
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[PADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cap_q      <= '0;
			cfg_stride_q   <= '0;
			cfg_cpu_base_q <= '0;
			cfg_gpu_base_q <= '0;
			cfg_gpu_vis_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAPACITY: cfg_cap_q      <= pwdata[CAP_W-1:0];
				REG_STRIDE:   cfg_stride_q   <= pwdata[STRIDE_W-1:0];
				REG_CPU_BASE: cfg_cpu_base_q <= pwdata;
				REG_GPU_BASE: cfg_gpu_base_q <= pwdata;
				REG_GPU_VIS:  cfg_gpu_vis_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CAPACITY: prdata = {{(PDATA_W-CAP_W){1'b0}}, cfg_cap_q};
			REG_STRIDE:   prdata = {{(PDATA_W-STRIDE_W){1'b0}}, cfg_stride_q};
			REG_CPU_BASE: prdata = cfg_cpu_base_q;
			REG_GPU_BASE: prdata = cfg_gpu_base_q;
			REG_GPU_VIS:  prdata = {{(PDATA_W-1){1'b0}}, cfg_gpu_vis_q};
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// handshake: one item in flight, result register frees the input side
	// ------------------------------------------------------------------
	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid & ~req_stall;
	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// capacity saturates at the maximum pool size
	assign cap_sat = (CNT_W'(cfg_cap_q) > CNT_W'(MAX_SLOTS)) ?
		CNT_W'(MAX_SLOTS) : CNT_W'(cfg_cap_q);
	// highest slot of the pool, pushed first so slot zero sits on top
	assign cap_m1 = SLOT_W'(pool_q - CNT_W'(1));

	// ------------------------------------------------------------------
	// memory port control
	// ------------------------------------------------------------------
	// pop address is top of stack, read is only used when fc_q != 0
	assign stack_ra = SLOT_W'(fc_q - CNT_W'(1));
	assign busy_ra  = req.free_index[SLOT_W-1:0];

	always_comb begin
		stack_we = 1'b0;
		stack_wa = fill_q;
		stack_wd = cap_m1 - fill_q;
		busy_we  = 1'b0;
		busy_wa  = fill_q;
		busy_wd  = 1'b0;
		case (state_q)
			S_INIT: begin
				// refill stack entry and clear its busy bit
				stack_we = 1'b1;
				busy_we  = 1'b1;
			end
			S_ALLOC_RD: begin
				busy_we = 1'b1;
				busy_wa = stack_rdata;
				busy_wd = 1'b1;
			end
			S_FREE_RD: begin
				// push only a slot that really was busy
				if (busy_rdata) begin
					busy_we  = 1'b1;
					busy_wa  = idx_q;
					busy_wd  = 1'b0;
					stack_we = (fc_q < CNT_W'(MAX_SLOTS));
					stack_wa = fc_q[SLOT_W-1:0];
					stack_wd = idx_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_wa] <= stack_wd;
		end
		stack_rdata <= stack_mem[stack_ra];
	end

	always_ff @(posedge clk) begin
		if (busy_we) begin
			busy_mem[busy_wa] <= busy_wd;
		end
		busy_rdata <= busy_mem[busy_ra];
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fc_q        <= '0;
			pool_q      <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if ((state_q == S_RESP) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						unique case (req.req_type)
							REQ_ALLOC: begin
								if (fc_q == '0) begin
									state_q <= S_RESP;
								end else begin
									// stack read issued this cycle
									fc_q    <= fc_q - CNT_W'(1);
									state_q <= S_ALLOC_RD;
								end
							end
							REQ_FREE: begin
								if (req.handle_present &&
								    (req.free_index < 16'(pool_q))) begin
									state_q <= S_FREE_RD;
								end else begin
									state_q <= S_RESP;
								end
							end
							REQ_INIT: begin
								pool_q <= cap_sat;
								fc_q   <= cap_sat;
								fill_q <= '0;
								state_q <= (cap_sat == '0) ? S_RESP : S_INIT;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_ALLOC_RD: begin
					state_q <= S_RESP;
				end
				S_FREE_RD: begin
					if (busy_rdata && (fc_q < CNT_W'(MAX_SLOTS))) begin
						fc_q <= fc_q + CNT_W'(1);
					end
					state_q <= S_RESP;
				end
				S_INIT: begin
					fill_q <= fill_q + SLOT_W'(1);
					if (fill_q == cap_m1) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result bookkeeping (payload, no reset)
	// ------------------------------------------------------------------
	assign prod_ext = {{(ADDR_W-PROD_W){1'b0}}, prod_q};

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					idx_q       <= req.free_index[SLOT_W-1:0];
					res_grant_q <= 1'b0;
					case (req.req_type)
						REQ_ALLOC: begin
							res_status_q <= (fc_q == '0) ? ST_EXHAUSTED : ST_OK;
						end
						REQ_FREE: begin
							if (!req.handle_present) begin
								res_status_q <= ST_IGNORED;
							end else if (req.free_index >= 16'(pool_q)) begin
								res_status_q <= ST_OUT_OF_RANGE;
							end else begin
								res_status_q <= ST_OK;
							end
						end
						default: res_status_q <= ST_OK;
					endcase
				end
			end
			S_ALLOC_RD: begin
				// popped slot and its byte offset
				res_grant_q <= 1'b1;
				slot_q      <= stack_rdata;
				prod_q      <= PROD_W'(stack_rdata) * PROD_W'(cfg_stride_q);
			end
			S_FREE_RD: begin
				if (!busy_rdata) begin
					res_status_q <= ST_DOUBLE_FREE;
				end
			end
			S_RESP: begin
				if (rsp_free) begin
					rsp_q.status  <= res_status_q;
					rsp_q.granted <= res_grant_q;
					if (res_grant_q) begin
						rsp_q.slot_index  <= slot_q;
						rsp_q.cpu_address <= cfg_cpu_base_q + prod_ext;
						rsp_q.gpu_address <= cfg_gpu_vis_q ?
							(cfg_gpu_base_q + prod_ext) : '0;
					end else begin
						rsp_q.slot_index  <= '0;
						rsp_q.cpu_address <= '0;
						rsp_q.gpu_address <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_fc_in_pool, fc_q <= pool_q, "free count above pool size")
	`ASSERT_ALWAYS(a_pool_max, pool_q <= CNT_W'(MAX_SLOTS), "pool size above maximum")
	`ASSERT_ALWAYS(a_fill_in_pool, (state_q != S_INIT) || (CNT_W'(fill_q) < pool_q), "init sweep past pool")
	`ASSERT_NEXT(a_pop_count, req_xfer && (req.req_type == REQ_ALLOC) && (fc_q != '0), fc_q == $past(fc_q) - CNT_W'(1), "pop did not decrement free count")
	`ASSERT_ALWAYS(a_grant_ok, !rsp_valid_q || !rsp_q.granted || (rsp_q.status == ST_OK), "grant with error status")

endmodule
